/* hw/rtl/vwsl_pkg.sv */
`timescale 1ns / 1ps
package vwsl_pkg;

    localparam int DATA_W    = 32;
    localparam int PITCH_W   = 31;
    localparam int IDX_W     = 10;
    localparam int SLOT_W    = 3;
    localparam int CNT_W     = 4;
    localparam int LABEL_W   = 4;
    localparam int CFG_IDX_W = 3;

    // centre (2x, units of 2^-16) and split multiplier operand
    localparam int C_W     = 44;
    localparam int C_LO_W  = 22;
    localparam int MB_W    = 23;
    localparam int PROD_W  = DATA_W + MB_W;
    localparam int ACC_W   = 78;
    localparam int OFF_SH  = 17;
    localparam int CMP_W   = 7;
    localparam int GD_W    = 17;

    localparam logic [2:0] K_CENTRE_LAST = 3'd2;
    localparam logic [2:0] K_MUL_LAST    = 3'd5;

    localparam logic [PITCH_W-1:0] PITCH_RST = 31'd65536;
    localparam logic [CNT_W-1:0]   COUNT_RST = 4'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PITCH_X,
        CFG_PITCH_Y,
        CFG_PITCH_Z,
        CFG_ORIGIN_X,
        CFG_ORIGIN_Y,
        CFG_ORIGIN_Z,
        CFG_PLANE_COUNT
    } t_cfg_idx;

    typedef enum logic {
        ACT_LOAD,
        ACT_CLASSIFY
    } t_action;

    typedef enum logic [3:0] {
        MOP_CX,
        MOP_CY,
        MOP_CZ,
        MOP_NX_LO,
        MOP_NX_HI,
        MOP_NY_LO,
        MOP_NY_HI,
        MOP_NZ_LO,
        MOP_NZ_HI
    } t_mop;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CENTRE,
        S_CWAIT,
        S_RD,
        S_MUL,
        S_DRAIN,
        S_EVAL,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                     action;
        logic [SLOT_W-1:0]        plane_slot;
        logic signed [DATA_W-1:0] normal_x;
        logic signed [DATA_W-1:0] normal_y;
        logic signed [DATA_W-1:0] normal_z;
        logic signed [DATA_W-1:0] plane_offset;
        logic [IDX_W-1:0]         voxel_x;
        logic [IDX_W-1:0]         voxel_y;
        logic [IDX_W-1:0]         voxel_z;
    } t_in_req;

    typedef struct packed {
        logic [LABEL_W-1:0] sector_label;
        logic               hit;
    } t_out_req;

    typedef struct packed {
        logic load;
        logic start;
        logic rd;
        logic acc_clr;
        logic mul_en;
        t_mop mop;
        logic eval;
        logic scan;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic go;
    } t_status;

endpackage

/* hw/rtl/vwsl_datapath.sv */
`timescale 1ns / 1ps
module vwsl_datapath #(
    parameter int MAX_PLANES = 8,
    parameter int GRID_DIM   = 1024,
    localparam int PL_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1,
    localparam int EN_W = $clog2(2 * MAX_PLANES),
    localparam int NP_W = $clog2(MAX_PLANES + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [vwsl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [vwsl_pkg::DATA_W-1:0]        i_cfg_data,
    input  vwsl_pkg::t_in_req                  i_in_req,
    input  vwsl_pkg::t_cmd                     i_cmd,
    input  logic [PL_W-1:0]                    i_plane,
    input  logic [EN_W-1:0]                    i_entry,
    output vwsl_pkg::t_status                  o_status,
    output logic [NP_W-1:0]                    o_n_eff,
    output vwsl_pkg::t_out_req                 o_out_req
);

    localparam int DW = vwsl_pkg::DATA_W;
    localparam int CW = vwsl_pkg::C_W;
    localparam int AW = vwsl_pkg::ACC_W;

    logic [vwsl_pkg::PITCH_W-1:0] r_pitch [3];
    logic signed [DW-1:0]         r_origin [3];
    logic [vwsl_pkg::CNT_W-1:0]   r_count;

    logic signed [DW-1:0] m_nx [MAX_PLANES];
    logic signed [DW-1:0] m_ny [MAX_PLANES];
    logic signed [DW-1:0] m_nz [MAX_PLANES];
    logic signed [DW-1:0] m_d  [MAX_PLANES];
    logic signed [DW-1:0] r_nx, r_ny, r_nz, r_d;

    logic [vwsl_pkg::IDX_W-1:0] r_vidx [3];
    logic                       r_go;
    logic signed [CW-1:0]       r_c [3];

    logic signed [DW-1:0]                 mul_a;
    logic signed [vwsl_pkg::MB_W-1:0]     mul_b;
    logic signed [vwsl_pkg::PROD_W-1:0]   r_prod;
    vwsl_pkg::t_mop                       r_use;
    logic                                 r_use_vld;
    logic signed [AW-1:0]                 r_acc;

    logic signed [AW-1:0] off_ext, v_p, v_m;
    logic [2*MAX_PLANES-1:0] r_pos, r_neg;
    logic [EN_W:0]   hi_idx, total, e_inc;
    logic [EN_W-1:0] e_nxt;
    logic [EN_W-1:0] r_label;
    logic            r_hit;
    logic            slot_ok, in_grid;
    logic [NP_W-1:0] n_eff;
    vwsl_pkg::t_out_req r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch[0]  <= vwsl_pkg::PITCH_RST;
            r_pitch[1]  <= vwsl_pkg::PITCH_RST;
            r_pitch[2]  <= vwsl_pkg::PITCH_RST;
            r_origin[0] <= '0;
            r_origin[1] <= '0;
            r_origin[2] <= '0;
            r_count     <= vwsl_pkg::COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (vwsl_pkg::t_cfg_idx'(i_cfg_index))
                vwsl_pkg::CFG_PITCH_X:     r_pitch[0]  <= i_cfg_data[vwsl_pkg::PITCH_W-1:0];
                vwsl_pkg::CFG_PITCH_Y:     r_pitch[1]  <= i_cfg_data[vwsl_pkg::PITCH_W-1:0];
                vwsl_pkg::CFG_PITCH_Z:     r_pitch[2]  <= i_cfg_data[vwsl_pkg::PITCH_W-1:0];
                vwsl_pkg::CFG_ORIGIN_X:    r_origin[0] <= i_cfg_data;
                vwsl_pkg::CFG_ORIGIN_Y:    r_origin[1] <= i_cfg_data;
                vwsl_pkg::CFG_ORIGIN_Z:    r_origin[2] <= i_cfg_data;
                vwsl_pkg::CFG_PLANE_COUNT: r_count     <= i_cfg_data[vwsl_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign n_eff = (vwsl_pkg::CMP_W'(r_count) > vwsl_pkg::CMP_W'(MAX_PLANES)) ?
                   NP_W'(MAX_PLANES) : NP_W'(r_count);
    assign o_n_eff = n_eff;

    // plane table
    assign slot_ok = vwsl_pkg::CMP_W'(i_in_req.plane_slot) < vwsl_pkg::CMP_W'(MAX_PLANES);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && slot_ok) begin
            m_nx[PL_W'(i_in_req.plane_slot)] <= i_in_req.normal_x;
            m_ny[PL_W'(i_in_req.plane_slot)] <= i_in_req.normal_y;
            m_nz[PL_W'(i_in_req.plane_slot)] <= i_in_req.normal_z;
            m_d[PL_W'(i_in_req.plane_slot)]  <= i_in_req.plane_offset;
        end
        if (i_cmd.rd) begin
            r_nx <= m_nx[i_plane];
            r_ny <= m_ny[i_plane];
            r_nz <= m_nz[i_plane];
            r_d  <= m_d[i_plane];
        end
    end

    // voxel capture
    assign in_grid = (vwsl_pkg::GD_W'(i_in_req.voxel_x) < vwsl_pkg::GD_W'(GRID_DIM)) &&
                     (vwsl_pkg::GD_W'(i_in_req.voxel_y) < vwsl_pkg::GD_W'(GRID_DIM)) &&
                     (vwsl_pkg::GD_W'(i_in_req.voxel_z) < vwsl_pkg::GD_W'(GRID_DIM));

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_vidx[0] <= i_in_req.voxel_x;
            r_vidx[1] <= i_in_req.voxel_y;
            r_vidx[2] <= i_in_req.voxel_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go <= 1'b0;
        end else if (i_cmd.start) begin
            r_go <= in_grid && (n_eff != '0);
        end
    end

    assign o_status.go = r_go;

    // shared multiplier, one product per cycle
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mop)
            vwsl_pkg::MOP_CX: begin
                mul_a = {1'b0, r_pitch[0]};
                mul_b = {12'b0, r_vidx[0], 1'b1};
            end
            vwsl_pkg::MOP_CY: begin
                mul_a = {1'b0, r_pitch[1]};
                mul_b = {12'b0, r_vidx[1], 1'b1};
            end
            vwsl_pkg::MOP_CZ: begin
                mul_a = {1'b0, r_pitch[2]};
                mul_b = {12'b0, r_vidx[2], 1'b1};
            end
            vwsl_pkg::MOP_NX_LO: begin
                mul_a = r_nx;
                mul_b = {1'b0, r_c[0][vwsl_pkg::C_LO_W-1:0]};
            end
            vwsl_pkg::MOP_NX_HI: begin
                mul_a = r_nx;
                mul_b = {r_c[0][CW-1], r_c[0][CW-1:vwsl_pkg::C_LO_W]};
            end
            vwsl_pkg::MOP_NY_LO: begin
                mul_a = r_ny;
                mul_b = {1'b0, r_c[1][vwsl_pkg::C_LO_W-1:0]};
            end
            vwsl_pkg::MOP_NY_HI: begin
                mul_a = r_ny;
                mul_b = {r_c[1][CW-1], r_c[1][CW-1:vwsl_pkg::C_LO_W]};
            end
            vwsl_pkg::MOP_NZ_LO: begin
                mul_a = r_nz;
                mul_b = {1'b0, r_c[2][vwsl_pkg::C_LO_W-1:0]};
            end
            vwsl_pkg::MOP_NZ_HI: begin
                mul_a = r_nz;
                mul_b = {r_c[2][CW-1], r_c[2][CW-1:vwsl_pkg::C_LO_W]};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
            r_use  <= i_cmd.mop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_vld <= 1'b0;
        end else begin
            r_use_vld <= i_cmd.mul_en;
        end
    end

    // product consumer: centre write or dot accumulate
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (r_use_vld) begin
            case (r_use) inside
                vwsl_pkg::MOP_CX:
                    r_c[0] <= r_prod[CW-1:0] +
                              {{(CW-DW-1){r_origin[0][DW-1]}}, r_origin[0], 1'b0};
                vwsl_pkg::MOP_CY:
                    r_c[1] <= r_prod[CW-1:0] +
                              {{(CW-DW-1){r_origin[1][DW-1]}}, r_origin[1], 1'b0};
                vwsl_pkg::MOP_CZ:
                    r_c[2] <= r_prod[CW-1:0] +
                              {{(CW-DW-1){r_origin[2][DW-1]}}, r_origin[2], 1'b0};
                vwsl_pkg::MOP_NX_LO, vwsl_pkg::MOP_NY_LO, vwsl_pkg::MOP_NZ_LO:
                    r_acc <= r_acc + AW'(r_prod);
                vwsl_pkg::MOP_NX_HI, vwsl_pkg::MOP_NY_HI, vwsl_pkg::MOP_NZ_HI:
                    r_acc <= r_acc + (AW'(r_prod) <<< vwsl_pkg::C_LO_W);
                default: ;
            endcase
        end
    end

    // sign of entry and its mirror
    assign off_ext = AW'($signed({r_d, {vwsl_pkg::OFF_SH{1'b0}}}));
    assign v_p     = off_ext + r_acc;
    assign v_m     = off_ext - r_acc;
    assign hi_idx  = (EN_W+1)'(i_plane) + (EN_W+1)'(n_eff);

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_pos[EN_W'(i_plane)]    <= !v_p[AW-1] && (v_p != '0);
            r_neg[EN_W'(i_plane)]    <= v_p[AW-1];
            r_pos[hi_idx[EN_W-1:0]]  <= !v_m[AW-1] && (v_m != '0);
            r_neg[hi_idx[EN_W-1:0]]  <= v_m[AW-1];
        end
    end

    // sector scan, one entry per cycle
    assign total = (EN_W+1)'(n_eff) << 1;
    assign e_inc = (EN_W+1)'(i_entry) + 1'b1;
    assign e_nxt = (e_inc == total) ? '0 : e_inc[EN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit   <= 1'b0;
            r_label <= '0;
        end else if (i_cmd.start) begin
            r_hit   <= 1'b0;
            r_label <= '0;
        end else if (i_cmd.scan && r_pos[i_entry] && r_neg[e_nxt]) begin
            r_hit   <= 1'b1;
            r_label <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out.sector_label <= vwsl_pkg::LABEL_W'(r_label);
            r_out.hit          <= r_hit;
        end
    end

    assign o_out_req = r_out;

endmodule

/* hw/rtl/vwsl_ctrl.sv */
`timescale 1ns / 1ps
module vwsl_ctrl #(
    parameter int MAX_PLANES = 8,
    localparam int PL_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1,
    localparam int EN_W = $clog2(2 * MAX_PLANES),
    localparam int NP_W = $clog2(MAX_PLANES + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_action,
    output logic              o_in_stall,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    input  vwsl_pkg::t_status i_status,
    input  logic [NP_W-1:0]   i_n_eff,
    output vwsl_pkg::t_cmd    o_cmd,
    output logic [PL_W-1:0]   o_plane,
    output logic [EN_W-1:0]   o_entry
);

    vwsl_pkg::t_state r_state, n_state;
    logic [2:0]       r_k, n_k;
    logic [PL_W-1:0]  r_pl, n_pl;
    logic [EN_W-1:0]  r_e, n_e;
    logic             r_out_vld, n_out_vld;
    logic             accept, out_free;
    logic [EN_W:0]    total;

    assign accept   = i_in_valid && (r_state == vwsl_pkg::S_IDLE);
    assign out_free = !r_out_vld || !i_out_stall;
    assign total    = (EN_W+1)'(i_n_eff) << 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= vwsl_pkg::S_IDLE;
            r_k       <= '0;
            r_pl      <= '0;
            r_e       <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_k       <= n_k;
            r_pl      <= n_pl;
            r_e       <= n_e;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_pl      = r_pl;
        n_e       = r_e;
        n_out_vld = (r_out_vld && i_out_stall) ? 1'b1 : 1'b0;
        unique case (r_state)
            vwsl_pkg::S_IDLE: begin
                if (accept && (i_in_action == vwsl_pkg::ACT_CLASSIFY)) begin
                    n_state = vwsl_pkg::S_CENTRE;
                    n_k     = '0;
                end
            end
            vwsl_pkg::S_CENTRE: begin
                n_k = r_k + 3'd1;
                if (r_k == vwsl_pkg::K_CENTRE_LAST) begin
                    n_state = vwsl_pkg::S_CWAIT;
                end
            end
            vwsl_pkg::S_CWAIT: begin
                n_pl    = '0;
                n_state = i_status.go ? vwsl_pkg::S_RD : vwsl_pkg::S_DONE;
            end
            vwsl_pkg::S_RD: begin
                n_k     = '0;
                n_state = vwsl_pkg::S_MUL;
            end
            vwsl_pkg::S_MUL: begin
                n_k = r_k + 3'd1;
                if (r_k == vwsl_pkg::K_MUL_LAST) begin
                    n_state = vwsl_pkg::S_DRAIN;
                end
            end
            vwsl_pkg::S_DRAIN: begin
                n_state = vwsl_pkg::S_EVAL;
            end
            vwsl_pkg::S_EVAL: begin
                if (NP_W'(r_pl) + 1'b1 == i_n_eff) begin
                    n_e     = '0;
                    n_state = vwsl_pkg::S_SCAN;
                end else begin
                    n_pl    = r_pl + 1'b1;
                    n_state = vwsl_pkg::S_RD;
                end
            end
            vwsl_pkg::S_SCAN: begin
                if ((EN_W+1)'(r_e) + 1'b1 == total) begin
                    n_state = vwsl_pkg::S_DONE;
                end else begin
                    n_e = r_e + 1'b1;
                end
            end
            vwsl_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    n_state   = vwsl_pkg::S_IDLE;
                end
            end
            default: n_state = vwsl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.mop     = vwsl_pkg::MOP_CX;
        o_in_stall    = 1'b1;
        unique case (r_state)
            vwsl_pkg::S_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.load  = accept && (i_in_action == vwsl_pkg::ACT_LOAD);
                o_cmd.start = accept && (i_in_action == vwsl_pkg::ACT_CLASSIFY);
            end
            vwsl_pkg::S_CENTRE: begin
                o_cmd.mul_en = 1'b1;
                case (r_k)
                    3'd0:    o_cmd.mop = vwsl_pkg::MOP_CX;
                    3'd1:    o_cmd.mop = vwsl_pkg::MOP_CY;
                    default: o_cmd.mop = vwsl_pkg::MOP_CZ;
                endcase
            end
            vwsl_pkg::S_CWAIT: ;
            vwsl_pkg::S_RD: begin
                o_cmd.rd      = 1'b1;
                o_cmd.acc_clr = 1'b1;
            end
            vwsl_pkg::S_MUL: begin
                o_cmd.mul_en = 1'b1;
                case (r_k)
                    3'd0:    o_cmd.mop = vwsl_pkg::MOP_NX_LO;
                    3'd1:    o_cmd.mop = vwsl_pkg::MOP_NX_HI;
                    3'd2:    o_cmd.mop = vwsl_pkg::MOP_NY_LO;
                    3'd3:    o_cmd.mop = vwsl_pkg::MOP_NY_HI;
                    3'd4:    o_cmd.mop = vwsl_pkg::MOP_NZ_LO;
                    default: o_cmd.mop = vwsl_pkg::MOP_NZ_HI;
                endcase
            end
            vwsl_pkg::S_DRAIN: ;
            vwsl_pkg::S_EVAL:  o_cmd.eval = 1'b1;
            vwsl_pkg::S_SCAN:  o_cmd.scan = 1'b1;
            vwsl_pkg::S_DONE:  o_cmd.push = out_free;
            default: ;
        endcase
    end

    assign o_plane     = r_pl;
    assign o_entry     = r_e;
    assign o_out_valid = r_out_vld;

endmodule

/* hw/rtl/voxel_wedge_sector_labeler.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_stall   i_in_req  (vwsl_pkg::t_in_req)
// out       output     o_out_valid / i_out_stall o_out_req (vwsl_pkg::t_out_req)
// cfg       input      i_cfg_we                  i_cfg_index, i_cfg_data
//
// A load request does not hold off the input. A classify request has one shared
// 32x23 multiplier do three centre products; for a voxel inside the grid (N
// planes in use, N > 0) it then does six partial dot products per plane and scans
// the extended entries for the sector, one per cycle, else it goes to the result.
// Reset is synchronous, active low; the plane table holds no reset value.
// A finished result sits in the output register while the next request is taken.

module voxel_wedge_sector_labeler #(
    parameter int MAX_PLANES = 8,
    parameter int GRID_DIM   = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  vwsl_pkg::t_in_req               i_in_req,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output vwsl_pkg::t_out_req              o_out_req,
    input  logic                            i_cfg_we,
    input  logic [vwsl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vwsl_pkg::DATA_W-1:0]     i_cfg_data
);

    localparam int PL_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int EN_W = $clog2(2 * MAX_PLANES);
    localparam int NP_W = $clog2(MAX_PLANES + 1);

    vwsl_pkg::t_cmd    cmd;
    vwsl_pkg::t_status status;
    logic [PL_W-1:0]   plane;
    logic [EN_W-1:0]   entry;
    logic [NP_W-1:0]   n_eff;

    vwsl_ctrl #(
        .MAX_PLANES (MAX_PLANES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_action (i_in_req.action),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_status    (status),
        .i_n_eff     (n_eff),
        .o_cmd       (cmd),
        .o_plane     (plane),
        .o_entry     (entry)
    );

    vwsl_datapath #(
        .MAX_PLANES (MAX_PLANES),
        .GRID_DIM   (GRID_DIM)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_req    (i_in_req),
        .i_cmd       (cmd),
        .i_plane     (plane),
        .i_entry     (entry),
        .o_status    (status),
        .o_n_eff     (n_eff),
        .o_out_req   (o_out_req)
    );

    a_nohit_label_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_req.hit) |-> (o_out_req.sector_label == '0))
        else $error("miss result carries a nonzero label");

    a_classify_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_req.action == vwsl_pkg::ACT_CLASSIFY))
        |=> o_in_stall)
        else $error("classify request did not hold off the input");

    a_push_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |-> (!o_out_valid || !i_out_stall))
        else $error("result pushed over a stalled output");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |=> o_out_valid)
        else $error("pushed result not presented");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
module tb;

    localparam int MAX_PL      = 8;
    localparam int WIDE_W      = 128;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES = 300;
    localparam int REPORT_MAX  = 10;
    localparam logic [vwsl_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    vwsl_pkg::t_in_req              in_req    = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    vwsl_pkg::t_out_req             out_req;
    logic                           cfg_we    = 1'b0;
    logic [vwsl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [vwsl_pkg::DATA_W-1:0]    cfg_data  = '0;

    // mirror of the block's configuration and plane table
    logic [vwsl_pkg::PITCH_W-1:0]       pitch_m [3] = '{vwsl_pkg::PITCH_RST,
                                                        vwsl_pkg::PITCH_RST,
                                                        vwsl_pkg::PITCH_RST};
    logic signed [vwsl_pkg::DATA_W-1:0] origin_m [3] = '{0, 0, 0};
    logic [vwsl_pkg::CNT_W-1:0]         planes_in_use = vwsl_pkg::COUNT_RST;
    logic signed [vwsl_pkg::DATA_W-1:0] tbl_nx [MAX_PL];
    logic signed [vwsl_pkg::DATA_W-1:0] tbl_ny [MAX_PL];
    logic signed [vwsl_pkg::DATA_W-1:0] tbl_nz [MAX_PL];
    logic signed [vwsl_pkg::DATA_W-1:0] tbl_d  [MAX_PL];

    vwsl_pkg::t_out_req sector_queue [$];
    int       failures      = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       hold_left     = 0;

    voxel_wedge_sector_labeler dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_req   (out_req),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int sign_of(input logic signed [WIDE_W-1:0] v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic vwsl_pkg::t_out_req predict_sector(input vwsl_pkg::t_in_req r);
        logic signed [WIDE_W-1:0]       ctr [3];
        logic [vwsl_pkg::IDX_W-1:0]     vox [3];
        logic signed [WIDE_W-1:0]       dot;
        logic signed [WIDE_W-1:0]       off;
        int                             sgn [2*MAX_PL];
        int                             n, total, nxt, a, l;
        vwsl_pkg::t_out_req             res;
        res = '0;
        vox[0] = r.voxel_x;
        vox[1] = r.voxel_y;
        vox[2] = r.voxel_z;
        n = (planes_in_use > MAX_PL) ? MAX_PL : int'(planes_in_use);
        total = 2 * n;
        // centre kept doubled, in units of 2^-16
        for (a = 0; a < 3; a++)
            ctr[a] = (2 * $signed({{(WIDE_W-vwsl_pkg::IDX_W){1'b0}}, vox[a]}) + 1)
                     * $signed({{(WIDE_W-vwsl_pkg::PITCH_W){1'b0}}, pitch_m[a]})
                     + 2 * origin_m[a];
        for (l = 0; l < n; l++) begin
            dot = tbl_nx[l] * ctr[0] + tbl_ny[l] * ctr[1] + tbl_nz[l] * ctr[2];
            off = tbl_d[l];
            off = off <<< vwsl_pkg::OFF_SH;
            sgn[l]     = sign_of(off + dot);
            sgn[l + n] = sign_of(off - dot);
        end
        for (l = 0; l < total; l++) begin
            nxt = (l + 1 == total) ? 0 : l + 1;
            if (sgn[l] > 0 && sgn[nxt] < 0) begin
                res.sector_label = vwsl_pkg::LABEL_W'(l);
                res.hit          = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic logic signed [vwsl_pkg::DATA_W-1:0] rand_word();
        logic signed [vwsl_pkg::DATA_W-1:0] raw;
        int                                 w;
        raw = $urandom;
        w = $urandom_range(vwsl_pkg::DATA_W);
        if ($urandom_range(15) == 0) begin
            case ($urandom_range(3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0000_0001;
            endcase
        end
        if (w == 0)
            return '0;
        return raw >>> (vwsl_pkg::DATA_W - w);
    endfunction

    function automatic vwsl_pkg::t_in_req random_item();
        vwsl_pkg::t_in_req r;
        r.action       = ($urandom_range(99) < 85) ? vwsl_pkg::ACT_CLASSIFY
                                                   : vwsl_pkg::ACT_LOAD;
        r.plane_slot   = vwsl_pkg::SLOT_W'($urandom_range(MAX_PL - 1));
        r.normal_x     = rand_word();
        r.normal_y     = rand_word();
        r.normal_z     = rand_word();
        r.plane_offset = rand_word();
        r.voxel_x      = vwsl_pkg::IDX_W'($urandom_range(1023));
        r.voxel_y      = vwsl_pkg::IDX_W'($urandom_range(1023));
        r.voxel_z      = vwsl_pkg::IDX_W'($urandom_range(1023));
        return r;
    endfunction

    task automatic send_request(input vwsl_pkg::t_in_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (r.action == vwsl_pkg::ACT_LOAD) begin
            tbl_nx[r.plane_slot] = r.normal_x;
            tbl_ny[r.plane_slot] = r.normal_y;
            tbl_nz[r.plane_slot] = r.normal_z;
            tbl_d[r.plane_slot]  = r.plane_offset;
        end else begin
            sector_queue = {sector_queue, predict_sector(r)};
        end
    endtask

    task automatic load_plane(input int slot,
                              input logic [vwsl_pkg::DATA_W-1:0] nx, ny, nz, d);
        vwsl_pkg::t_in_req r;
        r = random_item();
        r.action       = vwsl_pkg::ACT_LOAD;
        r.plane_slot   = vwsl_pkg::SLOT_W'(slot);
        r.normal_x     = nx;
        r.normal_y     = ny;
        r.normal_z     = nz;
        r.plane_offset = d;
        send_request(r);
    endtask

    task automatic classify_voxel(input int x, y, z);
        vwsl_pkg::t_in_req r;
        r = random_item();
        r.action  = vwsl_pkg::ACT_CLASSIFY;
        r.voxel_x = vwsl_pkg::IDX_W'(x);
        r.voxel_y = vwsl_pkg::IDX_W'(y);
        r.voxel_z = vwsl_pkg::IDX_W'(z);
        send_request(r);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sector_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // writes every register in index order, then one unused index
    task automatic program_setup(input logic [vwsl_pkg::DATA_W-1:0] px, py, pz,
                                 ox, oy, oz, cnt);
        logic [vwsl_pkg::DATA_W-1:0]    vals [7];
        logic [vwsl_pkg::CFG_IDX_W-1:0] idx;
        int                             i;
        vals = '{px, py, pz, ox, oy, oz, cnt};
        for (i = 0; i <= 7; i++) begin
            idx = (i == 7) ? CFG_UNUSED : vwsl_pkg::CFG_IDX_W'(i);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= (i == 7) ? vwsl_pkg::DATA_W'($urandom) : vals[i];
            @(posedge clk);
            case (idx)
                vwsl_pkg::CFG_PITCH_X:     pitch_m[0]    = vals[i][vwsl_pkg::PITCH_W-1:0];
                vwsl_pkg::CFG_PITCH_Y:     pitch_m[1]    = vals[i][vwsl_pkg::PITCH_W-1:0];
                vwsl_pkg::CFG_PITCH_Z:     pitch_m[2]    = vals[i][vwsl_pkg::PITCH_W-1:0];
                vwsl_pkg::CFG_ORIGIN_X:    origin_m[0]   = vals[i];
                vwsl_pkg::CFG_ORIGIN_Y:    origin_m[1]   = vals[i];
                vwsl_pkg::CFG_ORIGIN_Z:    origin_m[2]   = vals[i];
                vwsl_pkg::CFG_PLANE_COUNT: planes_in_use = vals[i][vwsl_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [vwsl_pkg::DATA_W-1:0] random_pitch();
        logic [vwsl_pkg::PITCH_W-1:0] p;
        case ($urandom_range(9))
            0: p = '1;
            1: p = '0;
            2: p = vwsl_pkg::PITCH_W'($urandom);
            default: p = vwsl_pkg::PITCH_W'($urandom_range(1, 1 << 20));
        endcase
        return {1'($urandom_range(1)), p};
    endfunction

    task automatic program_random_setup();
        int cnt;
        case ($urandom_range(19))
            0: cnt = 0;
            1: cnt = $urandom_range(MAX_PL + 1, 15);
            2, 3: cnt = MAX_PL;
            4, 5, 6: cnt = $urandom_range(4, MAX_PL - 1);
            default: cnt = $urandom_range(1, 3);
        endcase
        program_setup(random_pitch(), random_pitch(), random_pitch(),
                      rand_word(), rand_word(), rand_word(),
                      {28'($urandom), 4'(cnt)});
    endtask

    task automatic report_mismatch(input string what,
                                   input vwsl_pkg::t_out_req want, got);
        failures++;
        if (failures <= REPORT_MAX)
            $display("%s: expected label %0d hit %0b, got label %0d hit %0b",
                     what, want.sector_label, want.hit, got.sector_label, got.hit);
    endtask

    always @(posedge clk) begin : check_results
        vwsl_pkg::t_out_req want;
        if (rst_n && out_valid && !out_stall) begin
            if (sector_queue.size() == 0) begin
                report_mismatch("unexpected result", '0, out_req);
            end else begin
                want = sector_queue.pop_front();
                if (out_req.sector_label !== want.sector_label || out_req.hit !== want.hit)
                    report_mismatch("sector mismatch", want, out_req);
            end
        end
    end

    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic test_directed();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_plane(0, 32'h8000_0000, 32'h0, 32'h0, 32'h7FFF_FFFF);
        load_plane(1, 32'h0001_0000, 32'h0, 32'h0, 32'hFE00_0000);
        load_plane(2, 32'h0, 32'h0001_0000, 32'h0, 32'hFE00_0000);
        load_plane(3, 32'h0, 32'h0, 32'hFFFF_0000, 32'h012C_0000);
        load_plane(4, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        load_plane(5, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 32'h0);
        load_plane(6, 32'h1234_5678, 32'h8000_0001, 32'h0001_0000, 32'h0F0F_0F0F);
        load_plane(7, 32'h0, 32'h0, 32'h0, 32'h0);
        classify_voxel(0, 0, 0);
        classify_voxel(1023, 1023, 1023);
        classify_voxel(512, 0, 1023);
        // no planes in use
        settle();
        program_setup(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 0, 32'h0);
        classify_voxel(0, 0, 0);
        classify_voxel(1023, 0, 0);
        // widest pitch, lowest origin, full table
        settle();
        program_setup(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd8);
        classify_voxel(0, 0, 0);
        classify_voxel(1023, 1023, 1023);
        classify_voxel(511, 511, 511);
        // zero pitch, highest origin, count above the table size
        settle();
        program_setup(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFC);
        classify_voxel(3, 700, 1023);
        classify_voxel(1023, 0, 512);
        settle();
        program_setup(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 0, 32'd2);
        classify_voxel(600, 400, 100);
        classify_voxel(100, 600, 500);
    endtask

    task automatic test_receiver_hold();
        vwsl_pkg::t_in_req r;
        int                i;
        settle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = HOLD_CYCLES;
        for (i = 0; i < 40; i++) begin
            r = random_item();
            r.action = vwsl_pkg::ACT_CLASSIFY;
            send_request(r);
        end
    endtask

    task automatic test_sender_pause();
        int i;
        send_idle_pct = 13;
        recv_idle_pct = 46;
        for (i = 0; i < 25; i++)
            send_request(random_item());
        in_valid <= 1'b0;
        @(posedge clk);
        while (sector_queue.size() != 0)
            @(posedge clk);
        for (i = 0; i < 25; i++)
            send_request(random_item());
    endtask

    task automatic test_random_phase(input int send_pct, recv_pct, count);
        int i;
        for (i = 0; i < count; i++) begin
            if (i % 100 == 0) begin
                settle();
                send_idle_pct = send_pct;
                recv_idle_pct = recv_pct;
                program_random_setup();
            end
            send_request(random_item());
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_receiver_hold();
        test_random_phase(13, 46, 580);
        test_sender_pause();
        test_random_phase(46, 13, 580);
        test_random_phase(0, 0, 580);
        settle();
        if (failures == 0 && sector_queue.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #30ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
